// ===== sv/block_chain_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block chain allocator
// Shared implication and next-cycle forms with reset disable.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CHAIN_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_CHAIN_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define BCA_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define BCA_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// Block chain allocator package
// Default sizes, operation and status codes, and shared types.
// ----------------------------------------------------------------------------
package bca_pkg;

	localparam int NUM_BLOCKS_DEF  = 1024;
	localparam int BLOCK_BYTES_DEF = 4096;

	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int OFFSET_W = 22;

	localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
	localparam logic [OP_W-1:0] OP_NEXT       = 3'd1;
	localparam logic [OP_W-1:0] OP_EXTEND     = 3'd2;
	localparam logic [OP_W-1:0] OP_SEEK       = 3'd3;
	localparam logic [OP_W-1:0] OP_FREE_CHAIN = 3'd4;
	localparam logic [OP_W-1:0] OP_FREE_BLOCK = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CHAIN_END  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd3;

	typedef struct packed {
		logic link;
		logic queue;
	} mem_we_t;

endpackage

// ===== sv/bca_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bca_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/bca_ctrl.sv =====
// ----------------------------------------------------------------------------
// Block chain allocator sequencer
// Writes the identity into both memories after reset, then runs each operation
// as a read of the link and free queue memories, with link walks for seek and free_chain.
// ----------------------------------------------------------------------------
`include "block_chain_allocator_top_macros.svh"

module bca_ctrl #(
	parameter int NUM_BLOCKS  = bca_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = bca_pkg::BLOCK_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic [bca_pkg::OP_W-1:0]              operation,
	input  logic [$clog2(NUM_BLOCKS)-1:0]         block,
	input  logic [bca_pkg::OFFSET_W-1:0]          byte_offset,
	output bca_pkg::mem_we_t                      mem_we,
	output logic [$clog2(NUM_BLOCKS)-1:0]         link_raddr,
	output logic [$clog2(NUM_BLOCKS)-1:0]         link_waddr,
	output logic [$clog2(NUM_BLOCKS)-1:0]         link_wdata,
	input  logic [$clog2(NUM_BLOCKS)-1:0]         link_rdata,
	output logic [$clog2(NUM_BLOCKS)-1:0]         queue_raddr,
	output logic [$clog2(NUM_BLOCKS)-1:0]         queue_waddr,
	output logic [$clog2(NUM_BLOCKS)-1:0]         queue_wdata,
	input  logic [$clog2(NUM_BLOCKS)-1:0]         queue_rdata,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic [$clog2(NUM_BLOCKS)-1:0]         res_block,
	output logic [$clog2(BLOCK_BYTES)-1:0]        res_offset,
	output logic [$clog2(NUM_BLOCKS+1)-1:0]       res_freed,
	output logic [bca_pkg::STATUS_W-1:0]          res_status
);

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int OW = $clog2(BLOCK_BYTES);
	localparam int FW = bca_pkg::OFFSET_W;
	localparam logic [FW-1:0] BB_OFF   = FW'(BLOCK_BYTES);
	localparam logic [CW-1:0] CAPACITY = CW'(NUM_BLOCKS);
	localparam logic [BW-1:0] LAST_BLK = BW'(NUM_BLOCKS - 1);

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_HOLD
	} state_t;

	state_t                        state_q;
	logic [BW-1:0]                 init_cnt_q;
	logic [BW-1:0]                 head_q;
	logic [BW-1:0]                 tail_q;
	logic [CW-1:0]                 total_q;
	logic [bca_pkg::OP_W-1:0]      op_q;
	logic [BW-1:0]                 cur_q;
	logic [FW-1:0]                 rem_q;
	logic [CW-1:0]                 freed_q;
	logic [BW-1:0]                 hold_block_q;
	logic [OW-1:0]                 hold_offset_q;
	logic [CW-1:0]                 hold_freed_q;
	logic [bca_pkg::STATUS_W-1:0]  hold_status_q;

	logic [BW-1:0]                 blk_mod;
	logic                          link_end;
	logic                          q_empty;
	logic                          q_full;
	logic                          fin;
	logic                          walk;
	logic                          pop;
	logic                          push;
	logic                          lwe;
	logic [BW-1:0]                 lwdata;
	logic [BW-1:0]                 c_block;
	logic [OW-1:0]                 c_offset;
	logic [CW-1:0]                 c_freed;
	logic [bca_pkg::STATUS_W-1:0]  c_status;
	logic [BW-1:0]                 head_inc;
	logic [BW-1:0]                 tail_inc;
	logic [CW:0]                   tail_sum;
	logic [BW-1:0]                 exp_tail;

	assign blk_mod  = ({1'b0, block} >= (BW+1)'(NUM_BLOCKS)) ? block - BW'(NUM_BLOCKS) : block;
	assign link_end = (link_rdata == cur_q);
	assign q_empty  = (total_q == '0);
	assign q_full   = (total_q == CAPACITY);
	assign head_inc = (head_q == LAST_BLK) ? '0 : head_q + BW'(1);
	assign tail_inc = (tail_q == LAST_BLK) ? '0 : tail_q + BW'(1);

	always_comb begin
		fin      = 1'b0;
		walk     = 1'b0;
		pop      = 1'b0;
		push     = 1'b0;
		lwe      = 1'b0;
		lwdata   = cur_q;
		c_block  = '0;
		c_offset = '0;
		c_freed  = '0;
		c_status = bca_pkg::ST_OK;
		if (state_q == S_EXEC) begin
			case (op_q)
				bca_pkg::OP_ALLOC: begin
					fin = 1'b1;
					if (!q_empty) begin
						pop     = 1'b1;
						c_block = queue_rdata;
					end else begin
						c_status = bca_pkg::ST_NO_FREE;
					end
				end
				bca_pkg::OP_NEXT: begin
					fin     = 1'b1;
					c_block = link_rdata;
					if (link_end) begin
						c_status = bca_pkg::ST_CHAIN_END;
					end
				end
				bca_pkg::OP_EXTEND: begin
					fin = 1'b1;
					if (!link_end) begin
						c_block = link_rdata;
					end else if (!q_empty) begin
						pop     = 1'b1;
						lwe     = 1'b1;
						lwdata  = queue_rdata;
						c_block = queue_rdata;
					end else begin
						c_block  = cur_q;
						c_status = bca_pkg::ST_NO_FREE;
					end
				end
				bca_pkg::OP_SEEK: begin
					c_block = cur_q;
					if (rem_q < BB_OFF) begin
						fin      = 1'b1;
						c_offset = rem_q[OW-1:0];
					end else if (link_end) begin
						fin      = 1'b1;
						c_status = bca_pkg::ST_CHAIN_END;
					end else begin
						walk = 1'b1;
					end
				end
				bca_pkg::OP_FREE_CHAIN: begin
					if (q_full) begin
						fin      = 1'b1;
						c_freed  = freed_q;
						c_status = bca_pkg::ST_QUEUE_FULL;
					end else begin
						push    = 1'b1;
						lwe     = 1'b1;
						c_freed = freed_q + CW'(1);
						if (link_end) begin
							fin = 1'b1;
						end else begin
							walk = 1'b1;
						end
					end
				end
				bca_pkg::OP_FREE_BLOCK: begin
					fin = 1'b1;
					if (q_full) begin
						c_status = bca_pkg::ST_QUEUE_FULL;
					end else begin
						push    = 1'b1;
						lwe     = 1'b1;
						c_freed = CW'(1);
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end
	end

	assign item_ready = (state_q == S_IDLE);

	assign link_raddr  = (state_q == S_IDLE) ? blk_mod : (walk ? link_rdata : cur_q);
	assign mem_we.link = (state_q == S_INIT) || lwe;
	assign link_waddr  = (state_q == S_INIT) ? init_cnt_q : cur_q;
	assign link_wdata  = (state_q == S_INIT) ? init_cnt_q : lwdata;

	assign queue_raddr  = head_q;
	assign mem_we.queue = (state_q == S_INIT) || push;
	assign queue_waddr  = (state_q == S_INIT) ? init_cnt_q : tail_q;
	assign queue_wdata  = (state_q == S_INIT) ? init_cnt_q : cur_q;

	assign res_valid  = fin || (state_q == S_HOLD);
	assign res_block  = (state_q == S_HOLD) ? hold_block_q  : c_block;
	assign res_offset = (state_q == S_HOLD) ? hold_offset_q : c_offset;
	assign res_freed  = (state_q == S_HOLD) ? hold_freed_q  : c_freed;
	assign res_status = (state_q == S_HOLD) ? hold_status_q : c_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			init_cnt_q    <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			total_q       <= CAPACITY;
			op_q          <= bca_pkg::OP_ALLOC;
			cur_q         <= '0;
			rem_q         <= '0;
			freed_q       <= '0;
			hold_block_q  <= '0;
			hold_offset_q <= '0;
			hold_freed_q  <= '0;
			hold_status_q <= bca_pkg::ST_OK;
		end else begin
			case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + BW'(1);
					if (init_cnt_q == LAST_BLK) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						op_q    <= operation;
						cur_q   <= blk_mod;
						rem_q   <= byte_offset;
						freed_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (pop) begin
						head_q  <= head_inc;
						total_q <= total_q - CW'(1);
					end
					if (push) begin
						tail_q  <= tail_inc;
						total_q <= total_q + CW'(1);
					end
					freed_q <= c_freed;
					if (walk) begin
						cur_q <= link_rdata;
						if (op_q == bca_pkg::OP_SEEK) begin
							rem_q <= rem_q - BB_OFF;
						end
					end
					if (fin) begin
						hold_block_q  <= c_block;
						hold_offset_q <= c_offset;
						hold_freed_q  <= c_freed;
						hold_status_q <= c_status;
						state_q       <= res_ready ? S_IDLE : S_HOLD;
					end
				end
				S_HOLD: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(total_q);
	assign exp_tail = (tail_sum >= (CW+1)'(NUM_BLOCKS)) ?
		BW'(tail_sum - (CW+1)'(NUM_BLOCKS)) : BW'(tail_sum);

	`BCA_ASSERT_IMP(a_total_bound, clk, arst_n, 1'b1, total_q <= CAPACITY, "Free count exceeds capacity.")
	`BCA_ASSERT_IMP(a_tail_tracks, clk, arst_n, 1'b1, tail_q == exp_tail, "Queue tail out of step.")
	`BCA_ASSERT_NXT(a_accept_exec, clk, arst_n, item_valid && item_ready, state_q == S_EXEC, "Beat lost.")
	`BCA_ASSERT_IMP(a_pop_xor_push, clk, arst_n, 1'b1, !(pop && push), "Pop and push together.")

endmodule

// ===== sv/block_chain_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Block chain allocator
// Link table and free block queue in memories, with a registered result.
// ----------------------------------------------------------------------------
// After reset the block writes the identity into the link table and the free
// queue and takes no beat until that is done. For each operation, the cycle in
// which the beat is accepted issues the registered read of the link and queue
// memories, and the execute state then updates them and hands the result to the
// output register, or holds it while that register cannot take it. Seek walks
// one link after another, and free_chain frees every block of the chain that it
// reaches in turn; both walks are paced by the one read port of the link memory.
// A finished result waits in the output register while the next beat is taken,
// and one more result may wait inside.
module block_chain_allocator_top #(
	parameter int NUM_BLOCKS  = bca_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = bca_pkg::BLOCK_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [bca_pkg::OP_W-1:0]          operation,
	input  logic [$clog2(NUM_BLOCKS)-1:0]     block,
	input  logic [bca_pkg::OFFSET_W-1:0]      byte_offset,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [$clog2(NUM_BLOCKS)-1:0]     result_block,
	output logic [$clog2(BLOCK_BYTES)-1:0]    in_block_offset,
	output logic [$clog2(NUM_BLOCKS+1)-1:0]   freed_count,
	output logic [bca_pkg::STATUS_W-1:0]      status
);

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int OW = $clog2(BLOCK_BYTES);

	bca_pkg::mem_we_t             mem_we;
	logic [BW-1:0]                link_raddr;
	logic [BW-1:0]                link_waddr;
	logic [BW-1:0]                link_wdata;
	logic [BW-1:0]                link_rdata;
	logic [BW-1:0]                queue_raddr;
	logic [BW-1:0]                queue_waddr;
	logic [BW-1:0]                queue_wdata;
	logic [BW-1:0]                queue_rdata;
	logic                         res_valid;
	logic                         res_ready;
	logic [BW-1:0]                res_block;
	logic [OW-1:0]                res_offset;
	logic [CW-1:0]                res_freed;
	logic [bca_pkg::STATUS_W-1:0] res_status;
	logic                         out_valid_q;

	bca_ram #(
		.WIDTH(BW),
		.DEPTH(NUM_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_we.link),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	bca_ram #(
		.WIDTH(BW),
		.DEPTH(NUM_BLOCKS)
	) u_queue_ram (
		.clk  (clk),
		.we   (mem_we.queue),
		.waddr(queue_waddr),
		.wdata(queue_wdata),
		.raddr(queue_raddr),
		.rdata(queue_rdata)
	);

	bca_ctrl #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.operation  (operation),
		.block      (block),
		.byte_offset(byte_offset),
		.mem_we     (mem_we),
		.link_raddr (link_raddr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_rdata (link_rdata),
		.queue_raddr(queue_raddr),
		.queue_waddr(queue_waddr),
		.queue_wdata(queue_wdata),
		.queue_rdata(queue_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_block  (res_block),
		.res_offset (res_offset),
		.res_freed  (res_freed),
		.res_status (res_status)
	);

	assign res_ready    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			result_block    <= '0;
			in_block_offset <= '0;
			freed_count     <= '0;
			status          <= bca_pkg::ST_OK;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q     <= 1'b1;
				result_block    <= res_block;
				in_block_offset <= res_offset;
				freed_count     <= res_freed;
				status          <= res_status;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/block_chain_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block chain allocator testbench
// Drives operation beats through the valid/ready input channel and checks
// every result beat against a predictor that keeps its own link table and
// free block queue. A directed pass covers the edge cases, then a chain free
// meets a full queue, and then randomised chain traffic runs under several
// patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module block_chain_allocator_top_tb;

	localparam int NUM_BLOCKS  = bca_pkg::NUM_BLOCKS_DEF;
	localparam int BLOCK_BYTES = bca_pkg::BLOCK_BYTES_DEF;
	localparam int OP_W        = bca_pkg::OP_W;
	localparam int STATUS_W    = bca_pkg::STATUS_W;
	localparam int OFF_W       = bca_pkg::OFFSET_W;
	localparam int BLK_W       = $clog2(NUM_BLOCKS);
	localparam int OFS_W       = $clog2(BLOCK_BYTES);
	localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
	localparam int STALL_LIMIT = 20000;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [BLK_W-1:0]    blk;
		logic [OFS_W-1:0]    ofs;
		logic [CNT_W-1:0]    freed;
		logic [STATUS_W-1:0] st;
	} alloc_result_t;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	logic [OP_W-1:0]     operation;
	logic [BLK_W-1:0]    block;
	logic [OFF_W-1:0]    byte_offset;
	logic                result_valid;
	logic                result_ready;
	logic [BLK_W-1:0]    result_block;
	logic [OFS_W-1:0]    in_block_offset;
	logic [CNT_W-1:0]    freed_count;
	logic [STATUS_W-1:0] status;

	logic [BLK_W-1:0] chain_link [NUM_BLOCKS];
	logic [BLK_W-1:0] free_list [NUM_BLOCKS];
	int free_rd;
	int free_wr;
	int free_avail;

	alloc_result_t    expected_results [$];
	logic [BLK_W-1:0] chain_heads [$];
	int mismatches;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	block_chain_allocator_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.operation       (operation),
		.block           (block),
		.byte_offset     (byte_offset),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result_block    (result_block),
		.in_block_offset (in_block_offset),
		.freed_count     (freed_count),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic pop_free(output logic [BLK_W-1:0] b);
		if (free_avail == 0) begin
			b = '0;
			return 1'b0;
		end
		b = free_list[free_rd];
		free_rd = (free_rd + 1) % NUM_BLOCKS;
		free_avail--;
		return 1'b1;
	endfunction

	function automatic logic push_free(input logic [BLK_W-1:0] b);
		if (free_avail >= NUM_BLOCKS)
			return 1'b0;
		free_list[free_wr] = b;
		free_wr = (free_wr + 1) % NUM_BLOCKS;
		free_avail++;
		return 1'b1;
	endfunction

	function automatic alloc_result_t apply_operation(input logic [OP_W-1:0] op,
			input logic [BLK_W-1:0] blk, input logic [OFF_W-1:0] ofs);
		alloc_result_t r;
		logic [BLK_W-1:0] nb;
		logic [BLK_W-1:0] cur;
		int steps;
		logic done;
		r = '0;
		case (op)
			bca_pkg::OP_ALLOC: begin
				if (pop_free(nb))
					r.blk = nb;
				else
					r.st = bca_pkg::ST_NO_FREE;
			end
			bca_pkg::OP_NEXT: begin
				r.blk = chain_link[blk];
				if (r.blk == blk)
					r.st = bca_pkg::ST_CHAIN_END;
			end
			bca_pkg::OP_EXTEND: begin
				if (chain_link[blk] != blk) begin
					r.blk = chain_link[blk];
				end else if (pop_free(nb)) begin
					chain_link[blk] = nb;
					r.blk = nb;
				end else begin
					r.blk = blk;
					r.st = bca_pkg::ST_NO_FREE;
				end
			end
			bca_pkg::OP_SEEK: begin
				cur = blk;
				steps = ofs / BLOCK_BYTES;
				r.ofs = OFS_W'(ofs % BLOCK_BYTES);
				while (steps > 0 && r.st == bca_pkg::ST_OK) begin
					if (chain_link[cur] == cur) begin
						r.st = bca_pkg::ST_CHAIN_END;
						r.ofs = '0;
					end else begin
						cur = chain_link[cur];
						steps--;
					end
				end
				r.blk = cur;
			end
			bca_pkg::OP_FREE_CHAIN: begin
				cur = blk;
				done = 1'b0;
				while (!done) begin
					nb = chain_link[cur];
					if (!push_free(cur)) begin
						r.st = bca_pkg::ST_QUEUE_FULL;
						done = 1'b1;
					end else begin
						r.freed = r.freed + CNT_W'(1);
						chain_link[cur] = cur;
						if (nb == cur)
							done = 1'b1;
						else
							cur = nb;
					end
				end
			end
			bca_pkg::OP_FREE_BLOCK: begin
				if (push_free(blk)) begin
					chain_link[blk] = blk;
					r.freed = CNT_W'(1);
				end else begin
					r.st = bca_pkg::ST_QUEUE_FULL;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int chain_length(input logic [BLK_W-1:0] head);
		logic [BLK_W-1:0] cur;
		int n;
		cur = head;
		n = 1;
		while (chain_link[cur] != cur && n < NUM_BLOCKS) begin
			cur = chain_link[cur];
			n++;
		end
		return n;
	endfunction

	function automatic logic [BLK_W-1:0] chain_block(input logic [BLK_W-1:0] head, input int idx);
		logic [BLK_W-1:0] cur;
		int n;
		cur = head;
		for (n = 0; n < idx && chain_link[cur] != cur; n++)
			cur = chain_link[cur];
		return cur;
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
			input logic [OFF_W-1:0] ofs, output alloc_result_t res);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		operation = op;
		block = blk;
		byte_offset = ofs;
		do @(posedge clk); while (!item_ready);
		res = apply_operation(op, blk, ofs);
		expected_results = {expected_results, res};
	endtask

	always @(negedge clk)
		result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin : check_results
		alloc_result_t want;
		alloc_result_t got;
		if (arst_n && result_valid && result_ready) begin
			got = '{result_block, in_block_offset, freed_count, status};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected: blk %0d ofs %0d freed %0d st %0d",
						$realtime, got.blk, got.ofs, got.freed, got.st);
			end else begin
				want = expected_results.pop_front();
				if (got.blk !== want.blk || got.ofs !== want.ofs ||
						got.freed !== want.freed || got.st !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected blk %0d ofs %0d freed %0d st %0d, got blk %0d ofs %0d freed %0d st %0d",
							$realtime, want.blk, want.ofs, want.freed, want.st,
							got.blk, got.ofs, got.freed, got.st);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		alloc_result_t r;
		logic [BLK_W-1:0] a;
		logic [BLK_W-1:0] b;
		logic [BLK_W-1:0] c;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(bca_pkg::OP_FREE_BLOCK, BLK_W'(5), '0, r);
		send_item(bca_pkg::OP_FREE_CHAIN, BLK_W'(NUM_BLOCKS - 1), '0, r);
		send_item(bca_pkg::OP_NEXT, '0, '0, r);
		send_item(bca_pkg::OP_NEXT, BLK_W'(NUM_BLOCKS - 1), '1, r);
		send_item(bca_pkg::OP_SEEK, '0, '0, r);
		send_item(bca_pkg::OP_SEEK, BLK_W'(NUM_BLOCKS - 1), OFF_W'(BLOCK_BYTES - 1), r);
		send_item(bca_pkg::OP_SEEK, BLK_W'(7), '1, r);
		send_item(bca_pkg::OP_ALLOC, '0, '0, r);
		a = r.blk;
		send_item(bca_pkg::OP_ALLOC, '1, '1, r);
		c = r.blk;
		send_item(bca_pkg::OP_EXTEND, a, '0, r);
		b = r.blk;
		send_item(bca_pkg::OP_EXTEND, a, '0, r);
		send_item(bca_pkg::OP_EXTEND, b, '0, r);
		send_item(bca_pkg::OP_NEXT, a, '0, r);
		send_item(bca_pkg::OP_NEXT, r.blk, '0, r);
		send_item(bca_pkg::OP_SEEK, a, OFF_W'(2 * BLOCK_BYTES + 100), r);
		send_item(bca_pkg::OP_SEEK, a, OFF_W'(3 * BLOCK_BYTES), r);
		send_item(bca_pkg::OP_FREE_BLOCK, c, '0, r);
		send_item(OP_SPARE_LO, '1, '1, r);
		send_item(OP_SPARE_HI, '1, '1, r);
		send_item(bca_pkg::OP_FREE_CHAIN, a, '0, r);
	endtask

	task automatic test_queue_full_in_chain();
		alloc_result_t r;
		logic [BLK_W-1:0] a;
		logic [BLK_W-1:0] b;
		logic [BLK_W-1:0] x;
		send_idle_pct = 0;
		recv_stall_pct = 55;
		send_item(bca_pkg::OP_ALLOC, '0, '0, r);
		a = r.blk;
		send_item(bca_pkg::OP_EXTEND, a, '0, r);
		b = r.blk;
		while (free_avail < NUM_BLOCKS - 1) begin
			x = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
			if (x != a && x != b)
				send_item(bca_pkg::OP_FREE_BLOCK, x, '0, r);
		end
		send_item(bca_pkg::OP_FREE_CHAIN, a, '0, r);
		send_item(bca_pkg::OP_FREE_BLOCK, b, '0, r);
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		alloc_result_t r;
		logic [BLK_W-1:0] h;
		logic [OFF_W-1:0] ofs;
		int sel;
		int len;
		int pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (chain_heads.size() == 0 && sel < 86)
				sel = 0;
			else if (chain_heads.size() >= 10 && sel < 86)
				sel = 72;
			pick = (chain_heads.size() == 0) ? 0 : $urandom_range(0, chain_heads.size() - 1);
			h = (chain_heads.size() == 0) ? '0 : chain_heads[pick];
			len = chain_length(h);
			if (sel < 14) begin
				send_item(bca_pkg::OP_ALLOC, BLK_W'($urandom), OFF_W'($urandom), r);
				if (r.st == bca_pkg::ST_OK)
					chain_heads = {chain_heads, r.blk};
			end else if (sel < 40) begin
				if (len < 24)
					send_item(bca_pkg::OP_EXTEND, chain_block(h, len - 1),
						OFF_W'($urandom), r);
				else
					send_item(bca_pkg::OP_EXTEND,
						chain_block(h, $urandom_range(0, len - 1)), '0, r);
			end else if (sel < 55) begin
				send_item(bca_pkg::OP_NEXT, chain_block(h, $urandom_range(0, len - 1)),
					OFF_W'($urandom), r);
			end else if (sel < 70) begin
				ofs = OFF_W'($urandom_range(0, len + 1) * BLOCK_BYTES +
					$urandom_range(0, BLOCK_BYTES - 1));
				send_item(bca_pkg::OP_SEEK, h, ofs, r);
			end else if (sel < 80) begin
				if ($urandom_range(0, 3) == 0)
					send_item(bca_pkg::OP_FREE_CHAIN,
						chain_block(h, $urandom_range(0, len - 1)), '0, r);
				else
					send_item(bca_pkg::OP_FREE_CHAIN, h, OFF_W'($urandom), r);
				chain_heads.delete(pick);
			end else if (sel < 86) begin
				send_item(bca_pkg::OP_FREE_BLOCK, chain_block(h, len - 1), '0, r);
			end else begin
				send_item(OP_W'($urandom_range(0, 7)), BLK_W'($urandom),
					OFF_W'($urandom), r);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = bca_pkg::OP_ALLOC;
		block = '0;
		byte_offset = '0;
		result_ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			chain_link[i] = BLK_W'(i);
			free_list[i] = BLK_W'(i);
		end
		free_rd = 0;
		free_wr = 0;
		free_avail = NUM_BLOCKS;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_queue_full_in_chain();
		test_random_traffic(155, 0, 0);
		test_random_traffic(155, 55, 0);
		test_random_traffic(155, 0, 55);
		test_random_traffic(155, 14, 14);

		@(negedge clk);
		item_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
